FILE: src/comment_string_blanker_defines.svh
// Assertion helpers used by comment_string_blanker.sv.
`ifndef COMMENT_STRING_BLANKER_DEFINES_SVH
`define COMMENT_STRING_BLANKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/csb_pkg.sv
`timescale 1ns / 1ps
package csb_pkg;

  localparam int LOOKAHEAD_DEF   = 6;
  localparam int QUOTE_SLOTS_DEF = 4;

  // Lexer modes.
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_LINE   = 3'd1;
  localparam logic [2:0] MODE_BLOCK  = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_TRIPLE = 3'd4;

  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_HASH      = 8'h23;

  // Configuration register indexes.
  localparam logic [2:0] REG_LINE_TEXT   = 3'd0;
  localparam logic [2:0] REG_LINE_LEN    = 3'd1;
  localparam logic [2:0] REG_BOPEN_TEXT  = 3'd2;
  localparam logic [2:0] REG_BOPEN_LEN   = 3'd3;
  localparam logic [2:0] REG_BCLOSE_TEXT = 3'd4;
  localparam logic [2:0] REG_BCLOSE_LEN  = 3'd5;
  localparam logic [2:0] REG_QUOTES      = 3'd6;
  localparam logic [2:0] REG_FLAGS       = 3'd7;

  typedef struct packed {
    logic [15:0] line_comment_text;
    logic [1:0]  line_open_len;
    logic [47:0] block_open_text;
    logic [2:0]  block_open_len;
    logic [31:0] block_close_text;
    logic [2:0]  block_close_len;
    logic [31:0] quote_chars;
    logic [2:0]  mode_flags;
  } cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] open_quote;
    logic [2:0] skip_count;
    logic       skip_blank;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{mode: MODE_NORMAL, open_quote: 8'd0,
                                       skip_count: 3'd0, skip_blank: 1'b0};

endpackage

FILE: src/csb_lexer.sv
`timescale 1ns / 1ps
// Decides the output byte for the front of the window and the next lexer state.
module csb_lexer #(
  parameter int LOOKAHEAD   = csb_pkg::LOOKAHEAD_DEF,
  parameter int QUOTE_SLOTS = csb_pkg::QUOTE_SLOTS_DEF,
  localparam int FILL_W     = $clog2(LOOKAHEAD + 1)
) (
  input  logic [LOOKAHEAD-1:0][7:0] win,
  input  logic [FILL_W-1:0]         avail,
  input  csb_pkg::cfg_t             cfg,
  input  csb_pkg::lex_state_t       st,
  output logic [7:0]                out_byte,
  output csb_pkg::lex_state_t       st_next
);

  localparam int LINE_N  = (LOOKAHEAD < 2) ? LOOKAHEAD : 2;
  localparam int OPEN_N  = (LOOKAHEAD < 6) ? LOOKAHEAD : 6;
  localparam int CLOSE_N = (LOOKAHEAD < 4) ? LOOKAHEAD : 4;
  localparam int SLOT_N  = (QUOTE_SLOTS < 4) ? QUOTE_SLOTS : 4;

  logic [7:0] c;
  logic       strip;
  logic       line_hit, open_hit, close_hit;
  logic       c_is_quote;
  logic       slot_live;
  logic [2:0] mode;

  // Delimiter compares run in parallel across the window.
  always_comb begin
    line_hit = (cfg.line_open_len != 2'd0) &&
               (int'(cfg.line_open_len) <= int'(avail)) &&
               (int'(cfg.line_open_len) <= LINE_N);
    for (int k = 0; k < LINE_N; k++) begin
      if ((k < int'(cfg.line_open_len)) && (win[k] != cfg.line_comment_text[8*k +: 8]))
        line_hit = 1'b0;
    end

    open_hit = (cfg.block_open_len != 3'd0) &&
               (int'(cfg.block_open_len) <= int'(avail)) &&
               (int'(cfg.block_open_len) <= OPEN_N);
    for (int k = 0; k < OPEN_N; k++) begin
      if ((k < int'(cfg.block_open_len)) && (win[k] != cfg.block_open_text[8*k +: 8]))
        open_hit = 1'b0;
    end

    close_hit = (cfg.block_close_len != 3'd0) &&
                (int'(cfg.block_close_len) <= int'(avail)) &&
                (int'(cfg.block_close_len) <= CLOSE_N);
    for (int k = 0; k < CLOSE_N; k++) begin
      if ((k < int'(cfg.block_close_len)) && (win[k] != cfg.block_close_text[8*k +: 8]))
        close_hit = 1'b0;
    end
  end

  // A zero slot ends the quote list; a zero byte is never a quote.
  always_comb begin
    c_is_quote = 1'b0;
    slot_live  = 1'b1;
    for (int s = 0; s < SLOT_N; s++) begin
      if (cfg.quote_chars[8*s +: 8] == 8'd0) slot_live = 1'b0;
      if (slot_live && (win[0] == cfg.quote_chars[8*s +: 8])) c_is_quote = 1'b1;
    end
    if (win[0] == 8'd0) c_is_quote = 1'b0;
  end

  always_comb begin
    c        = win[0];
    strip    = cfg.mode_flags[2];
    st_next  = st;
    out_byte = c;
    mode     = st.mode;
    if (st.skip_count != 3'd0) begin
      // Trailing bytes of a token matched earlier.
      st_next.skip_count = st.skip_count - 3'd1;
      out_byte = st.skip_blank ? csb_pkg::CHAR_SPACE : c;
    end else begin
      if ((mode == csb_pkg::MODE_BLOCK) && (cfg.block_close_len == 3'd0))
        mode = csb_pkg::MODE_NORMAL;
      st_next.mode = mode;
      case (mode)
        csb_pkg::MODE_LINE: begin
          if (c == csb_pkg::CHAR_NEWLINE) st_next.mode = csb_pkg::MODE_NORMAL;
          else out_byte = csb_pkg::CHAR_SPACE;
        end
        csb_pkg::MODE_BLOCK: begin
          if (close_hit) begin
            st_next.skip_count = cfg.block_close_len - 3'd1;
            st_next.skip_blank = 1'b1;
            st_next.mode       = csb_pkg::MODE_NORMAL;
            out_byte           = csb_pkg::CHAR_SPACE;
          end else if (c != csb_pkg::CHAR_NEWLINE) begin
            out_byte = csb_pkg::CHAR_SPACE;
          end
        end
        csb_pkg::MODE_STRING: begin
          out_byte = strip ? csb_pkg::CHAR_SPACE : c;
          if (c == csb_pkg::CHAR_BACKSLASH) begin
            if (int'(avail) >= 2) begin
              st_next.skip_count = 3'd1;
              st_next.skip_blank = strip && (win[1] != csb_pkg::CHAR_NEWLINE);
            end
          end else if (c == st.open_quote) begin
            st_next.mode = csb_pkg::MODE_NORMAL;
          end else if (c == csb_pkg::CHAR_NEWLINE) begin
            st_next.mode = csb_pkg::MODE_NORMAL;
            out_byte     = c;
          end
        end
        csb_pkg::MODE_TRIPLE: begin
          if ((c == st.open_quote) && (int'(avail) >= 3) &&
              (win[1] == st.open_quote) && (win[2] == st.open_quote)) begin
            st_next.skip_count = 3'd2;
            st_next.skip_blank = strip;
            st_next.mode       = csb_pkg::MODE_NORMAL;
            out_byte           = strip ? csb_pkg::CHAR_SPACE : c;
          end else begin
            out_byte = (strip && (c != csb_pkg::CHAR_NEWLINE)) ? csb_pkg::CHAR_SPACE : c;
          end
        end
        default: begin
          st_next.mode = csb_pkg::MODE_NORMAL;
          if (cfg.mode_flags[0] && (int'(avail) >= 3) && c_is_quote &&
              (win[1] == c) && (win[2] == c)) begin
            st_next.mode       = csb_pkg::MODE_TRIPLE;
            st_next.open_quote = c;
            st_next.skip_count = 3'd2;
            st_next.skip_blank = strip;
            out_byte           = strip ? csb_pkg::CHAR_SPACE : c;
          end else if (open_hit) begin
            st_next.mode       = csb_pkg::MODE_BLOCK;
            st_next.skip_count = cfg.block_open_len - 3'd1;
            st_next.skip_blank = 1'b1;
            out_byte           = csb_pkg::CHAR_SPACE;
          end else if (line_hit) begin
            st_next.mode       = csb_pkg::MODE_LINE;
            st_next.skip_count = {1'b0, cfg.line_open_len} - 3'd1;
            st_next.skip_blank = 1'b1;
            out_byte           = csb_pkg::CHAR_SPACE;
          end else if (cfg.mode_flags[1] && (c == csb_pkg::CHAR_HASH)) begin
            st_next.mode = csb_pkg::MODE_LINE;
            out_byte     = csb_pkg::CHAR_SPACE;
          end else if (c_is_quote) begin
            st_next.mode       = csb_pkg::MODE_STRING;
            st_next.open_quote = c;
            out_byte           = strip ? csb_pkg::CHAR_SPACE : c;
          end
        end
      endcase
    end
  end

endmodule

FILE: src/comment_string_blanker.sv
`timescale 1ns / 1ps
// Streams source text at one byte per cycle while the output queue has room and
// returns the same bytes with comments (and, when enabled, string literals) turned
// into spaces; newlines are kept. Delimiters are matched against a LOOKAHEAD-byte
// window, so a byte is lexed once the window fills, that is once LOOKAHEAD-1 further
// bytes have been accepted, and is then registered into the output queue. After an
// item with tlast the input is held off while the window drains, one byte per cycle
// while the queue has room, for the at most LOOKAHEAD bytes left; the last of them
// carries tlast and the lexer returns to normal code for the next text. A two-entry
// output queue lets input flow while one result waits downstream.
`include "comment_string_blanker_defines.svh"
module comment_string_blanker #(
  parameter int LOOKAHEAD   = csb_pkg::LOOKAHEAD_DEF,
  parameter int QUOTE_SLOTS = csb_pkg::QUOTE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast,   // out_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int FILL_W = $clog2(LOOKAHEAD + 1);
  localparam int IDX_W  = (LOOKAHEAD > 1) ? $clog2(LOOKAHEAD) : 1;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LOOKAHEAD);

  csb_pkg::cfg_t       cfg;
  csb_pkg::lex_state_t lex_st, lex_st_next;

  logic [LOOKAHEAD-1:0][7:0] win;
  logic [FILL_W-1:0]         fill;
  logic                      draining;
  logic [7:0]                lex_byte;
  logic                      lex_last;
  logic                      step, s_acc, pop;
  logic [IDX_W-1:0]          wr_idx;

  logic [1:0] ocnt;
  logic [7:0] q0_byte, q1_byte;
  logic       q0_last, q1_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        csb_pkg::REG_LINE_TEXT:   cfg.line_comment_text <= cfg_data[15:0];
        csb_pkg::REG_LINE_LEN:    cfg.line_open_len     <= cfg_data[1:0];
        csb_pkg::REG_BOPEN_TEXT:  cfg.block_open_text   <= cfg_data[47:0];
        csb_pkg::REG_BOPEN_LEN:   cfg.block_open_len    <= cfg_data[2:0];
        csb_pkg::REG_BCLOSE_TEXT: cfg.block_close_text  <= cfg_data[31:0];
        csb_pkg::REG_BCLOSE_LEN:  cfg.block_close_len   <= cfg_data[2:0];
        csb_pkg::REG_QUOTES:      cfg.quote_chars       <= cfg_data[31:0];
        csb_pkg::REG_FLAGS:       cfg.mode_flags        <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  csb_lexer #(
    .LOOKAHEAD   (LOOKAHEAD),
    .QUOTE_SLOTS (QUOTE_SLOTS)
  ) u_lexer (
    .win      (win),
    .avail    (fill),
    .cfg      (cfg),
    .st       (lex_st),
    .out_byte (lex_byte),
    .st_next  (lex_st_next)
  );

  // The front byte is lexed once the window is full, or during a drain, while the output queue has room.
  assign step     = ((fill == FILL_FULL) || (draining && (fill != '0))) && (ocnt != 2'd2);
  assign lex_last = draining && (fill == FILL_W'(1));
  assign s_axis_tready = !draining && ((fill != FILL_FULL) || (ocnt != 2'd2));
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign wr_idx   = step ? IDX_W'(fill - FILL_W'(1)) : IDX_W'(fill);

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < LOOKAHEAD - 1; i++) win[i] <= win[i+1];
    end
    if (s_acc) win[wr_idx] <= s_axis_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      draining <= 1'b0;
      lex_st   <= csb_pkg::LEX_RESET;
    end else begin
      if (s_acc && !step)      fill <= fill + FILL_W'(1);
      else if (!s_acc && step) fill <= fill - FILL_W'(1);
      if (s_acc && s_axis_tlast) draining <= 1'b1;
      if (step) begin
        if (lex_last) begin
          draining <= 1'b0;
          lex_st   <= csb_pkg::LEX_RESET;
        end else begin
          lex_st <= lex_st_next;
        end
      end
    end
  end

  // Output queue: q0 is the head shown on the master side.
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (ocnt != 2'd0);
  assign m_axis_tdata  = q0_byte;
  assign m_axis_tlast  = q0_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else begin
      if (step && !pop)      ocnt <= ocnt + 2'd1;
      else if (!step && pop) ocnt <= ocnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q0_byte <= step ? lex_byte : q1_byte;
      q0_last <= step ? lex_last : q1_last;
    end else if (step) begin
      if (ocnt == 2'd0) begin
        q0_byte <= lex_byte;
        q0_last <= lex_last;
      end else begin
        q1_byte <= lex_byte;
        q1_last <= lex_last;
      end
    end
  end

  `CSB_ASSERT_NEXT(a_hold_after_last, clk, rst, s_acc && s_axis_tlast, !s_axis_tready,
                   "input accepted right after the end of a text")
  `CSB_ASSERT_NEXT(a_drain_done, clk, rst, step && lex_last,
                   (fill == '0) && !draining && (lex_st == csb_pkg::LEX_RESET),
                   "window not empty or lexer not reset after the last byte")
  `CSB_ASSERT_NEXT(a_fill_grows, clk, rst, s_acc && !step,
                   fill == $past(fill) + FILL_W'(1),
                   "window fill did not advance on an accepted item")
  `CSB_ASSERT_NOW(a_fill_range, clk, rst, 1'b1, (fill <= FILL_FULL) && (ocnt <= 2'd2),
                  "window or output queue overflow")

endmodule
